FILE: sv/bwe_pkg.sv
// Package for the bit window extractor: widths, limits and register codes.
`timescale 1ns / 1ps

package bwe_pkg;

  // Field widths
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned BYTE_W  = 8;

  // Source byte counter saturates at this count
  localparam int unsigned MAX_SOURCE_BYTES = 8192;
  localparam int unsigned CNT_W = $clog2(MAX_SOURCE_BYTES + 1);

  // Bit position inside the source: start plus bits already taken
  localparam int unsigned POS_W  = LEN_W + 1;
  localparam int unsigned BIDX_W = POS_W - 3;

  // Bits per output byte, in the width of the length path
  localparam logic [LEN_W-1:0] BITS_PER_BYTE = LEN_W'(8);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = LEN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BIT   = 1'b0,
    CFG_LENGTH_BITS = 1'b1
  } cfg_reg_e;

  // Result status codes
  localparam logic STATUS_DATA  = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

endpackage

FILE: sv/bwe_src_if.sv
// Source byte channel: valid/ready handshake with the source byte payload.
`timescale 1ns / 1ps

interface bwe_src_if;
  import bwe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] src_byte;
  logic              src_last;

  modport source (output valid, output src_byte, output src_last, input ready);
  modport sink   (input valid, input src_byte, input src_last, output ready);
endinterface

FILE: sv/bwe_res_if.sv
// Result channel: valid/ready handshake with the extracted byte payload.
`timescale 1ns / 1ps

interface bwe_res_if;
  import bwe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              status;

  modport source (output valid, output out_byte, output out_last, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input status,
                  output ready);
endinterface

FILE: sv/bit_window_extract.sv
// Bit window extractor: repacks a bit window of a byte stream into bytes.
// Latency: a result is valid in the cycle after the source item that causes it.
// Throughput: one source item per cycle while results are taken; the stream
// state update and the one-entry result register set this figure.
// Input is stalled only while the result register holds an item not yet taken.
// Reset (rst_ni low, asynchronous) clears all but the result payload registers.
`timescale 1ns / 1ps

module bit_window_extract (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bwe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bwe_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  bwe_src_if.sink                        src,
  bwe_res_if.source                      res
);
  import bwe_pkg::*;

  // Configuration registers
  logic [START_W-1:0] start_q;
  logic [LEN_W-1:0]   length_q;

  // Stream state
  logic [CNT_W-1:0]   seen_q, seen_d;
  logic [BYTE_W-1:0]  held_q, held_d;
  logic [LEN_W-1:0]   left_q, left_d;
  logic [LEN_W-1:0]   taken_q, taken_d;
  logic               done_q, done_d;

  // Result register
  logic               res_valid_q;
  logic [BYTE_W-1:0]  res_byte_q, res_byte_d;
  logic               res_last_q, res_last_d;
  logic               res_status_q, res_status_d;
  logic               emit;

  // Per-item datapath
  logic               accept;
  logic               first_byte;
  logic               in_range;
  logic [LEN_W-1:0]   cur_left;
  logic [LEN_W-1:0]   cur_taken;
  logic               cur_done;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_end;
  logic [3:0]         nb;
  logic [2:0]         shift;
  logic [2*BYTE_W-1:0] pair;
  logic [BYTE_W-1:0]  val;
  logic [BYTE_W-1:0]  mask;
  logic               hit;
  logic [LEN_W-1:0]   left_n;
  logic [LEN_W-1:0]   taken_n;
  logic               done_n;

  assign src.ready = !res_valid_q || res.ready;
  assign accept    = src.valid && src.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_START_BIT:   start_q  <= cfg_wdata_i[START_W-1:0];
        CFG_LENGTH_BITS: length_q <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window position and byte assembly for the current source byte
  always_comb begin
    first_byte = (seen_q == '0);
    in_range   = (seen_q < CNT_W'(MAX_SOURCE_BYTES));
    cur_left   = first_byte ? length_q : left_q;
    cur_taken  = first_byte ? '0 : taken_q;
    cur_done   = first_byte ? (length_q == '0) : done_q;

    pos     = POS_W'(start_q) + POS_W'(cur_taken);
    nb      = (cur_left < BITS_PER_BYTE) ? cur_left[3:0] : 4'd8;
    pos_end = pos + POS_W'(nb) - POS_W'(1);
    shift   = pos[2:0];

    // held byte below, current byte above, shifted down to the window bit
    pair = {src.src_byte, held_q} >> shift;
    if (pos[POS_W-1:3] == pos_end[POS_W-1:3]) begin
      val = src.src_byte >> shift;
    end else begin
      val = pair[BYTE_W-1:0];
    end
    mask = BYTE_W'((9'd1 << nb) - 9'd1);

    hit     = !cur_done && in_range && (pos_end[POS_W-1:3] == BIDX_W'(seen_q));
    left_n  = hit ? (cur_left - LEN_W'(nb)) : cur_left;
    taken_n = hit ? (cur_taken + LEN_W'(nb)) : cur_taken;
    done_n  = hit ? (left_n == '0) : cur_done;
  end

  // Result selection and next stream state
  always_comb begin
    emit         = hit;
    res_byte_d   = val & mask;
    res_last_d   = done_n;
    res_status_d = STATUS_DATA;
    if (src.src_last && !done_n) begin
      // source ended before the window was covered
      emit         = 1'b1;
      res_byte_d   = '0;
      res_last_d   = 1'b1;
      res_status_d = STATUS_SHORT;
    end

    left_d = left_n;
    done_d = done_n;
    if (src.src_last) begin
      seen_d  = '0;
      held_d  = '0;
      taken_d = '0;
    end else begin
      seen_d  = in_range ? (seen_q + CNT_W'(1)) : seen_q;
      held_d  = src.src_byte;
      taken_d = taken_n;
    end
  end

  // Stream state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      held_q  <= '0;
      left_q  <= '0;
      taken_q <= '0;
      done_q  <= 1'b0;
    end else if (accept) begin
      seen_q  <= seen_d;
      held_q  <= held_d;
      left_q  <= left_d;
      taken_q <= taken_d;
      done_q  <= done_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= emit;
    end else if (res.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_byte_q   <= res_byte_d;
      res_last_q   <= res_last_d;
      res_status_q <= res_status_d;
    end
  end

  assign res.valid    = res_valid_q;
  assign res.out_byte = res_byte_q;
  assign res.out_last = res_last_q;
  assign res.status   = res_status_q;

endmodule

FILE: sv/bwe_checker.sv
// Port-level checks for the bit window extractor, bound to its module.
`timescale 1ns / 1ps

module bwe_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      src_valid_i,
  input logic                      src_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [bwe_pkg::BYTE_W-1:0] res_byte_i,
  input logic                      res_last_i,
  input logic                      res_status_i
);
  import bwe_pkg::*;

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_byte_i) && $stable(res_last_i)
      && $stable(res_status_i))
    else $error("result payload changed while stalled");

  // An error result is a zero byte that closes the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i == STATUS_SHORT) |-> res_last_i && (res_byte_i == '0))
    else $error("error result not marked last or not zero");

  // A full result register holds off the source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !src_ready_i)
    else $error("source accepted while result register full");

  // A new result only follows an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(src_valid_i && src_ready_i))
    else $error("result appeared without an accepted item");

endmodule

bind bit_window_extract bwe_checker u_bwe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .src_valid_i  (src.valid),
  .src_ready_i  (src.ready),
  .res_valid_i  (res.valid),
  .res_ready_i  (res.ready),
  .res_byte_i   (res.out_byte),
  .res_last_i   (res.out_last),
  .res_status_i (res.status)
);

FILE: tb/tb_bit_window_extract.sv
// Self-checking testbench for the bit window extractor, with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_bit_window_extract;
  import bwe_pkg::*;

  localparam int unsigned RUN_LIMIT    = 200_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned RAND_ITEMS   = 500;
  localparam int unsigned CALM_ITEMS   = 70;

  // One extracted item as seen on the result channel
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              status;
  } window_res_t;

  // Predicts the window bytes and checks the result channel against them
  class window_scoreboard;
    window_res_t expected_bytes[$];
    int unsigned errors;
    int unsigned start_reg, len_reg;
    int unsigned seen, held, left, taken;
    bit          done;

    function new();
      errors    = 0;
      start_reg = 0;
      len_reg   = 0;
      seen      = 0;
      held      = 0;
      left      = 0;
      taken     = 0;
      done      = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, int unsigned value);
      if (idx == CFG_START_BIT) start_reg = value & 32'hFFFF;
      else len_reg = value & 32'h1FFFF;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // Note an accepted source item and queue the result it causes, if any
    function void take_source(logic [BYTE_W-1:0] src_b, logic src_l);
      int unsigned cur, pos, nb, endb, first, r, val, mask;
      window_res_t res;
      bit          hit;
      cur = src_b;
      hit = 1'b0;
      res = '0;
      // New stream: reload the window
      if (seen == 0) begin
        left  = len_reg;
        taken = 0;
        done  = (left == 0);
      end
      if (!done && seen < MAX_SOURCE_BYTES) begin
        pos   = start_reg + taken;
        nb    = (left < 8) ? left : 8;
        endb  = (pos + nb - 1) >> 3;
        first = pos >> 3;
        r     = pos & 7;
        // Output byte completes on this source byte
        if (endb == seen) begin
          mask = ((1 << nb) - 1) & 8'hFF;
          if (first == endb) val = cur >> r;
          else val = ((held >> r) | (cur << (8 - r))) & 8'hFF;
          val   = val & mask;
          left  = left - nb;
          taken = taken + nb;
          done  = (left == 0);
          res.data   = val[BYTE_W-1:0];
          res.last   = done;
          res.status = STATUS_DATA;
          hit = 1'b1;
        end
      end
      held = cur;
      if (seen < MAX_SOURCE_BYTES) seen++;
      // End of stream: short source turns into an error item
      if (src_l) begin
        if (!done) begin
          res.data   = '0;
          res.last   = 1'b1;
          res.status = STATUS_SHORT;
          hit = 1'b1;
        end
        seen  = 0;
        held  = 0;
        taken = 0;
      end
      if (hit) expected_bytes.insert(expected_bytes.size(), res);
    endfunction

    // Compare one accepted result item with the oldest expectation
    function void check_result(logic [BYTE_W-1:0] b, logic l, logic s);
      window_res_t exp_r;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %0h out_last %0b status %0b", b, l, s);
        errors++;
        return;
      end
      exp_r = expected_bytes.pop_front();
      if (b !== exp_r.data) begin
        $error("out_byte mismatch: expected %0h, actual %0h", exp_r.data, b);
        errors++;
      end
      if (l !== exp_r.last) begin
        $error("out_last mismatch: expected %0b, actual %0b", exp_r.last, l);
        errors++;
      end
      if (s !== exp_r.status) begin
        $error("status mismatch: expected %0b, actual %0b", exp_r.status, s);
        errors++;
      end
    endfunction
  endclass

  bit                     clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  bwe_src_if src_if ();
  bwe_res_if res_if ();

  window_scoreboard sb;
  int unsigned      src_count;
  bit               src_idle_on;
  bit               res_idle_on;
  bit               hold_req;

  bit_window_extract dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .src         (src_if),
    .res         (res_if)
  );

  // Clock
  always #5 clk_i = ~clk_i;

  // Offer one source item, with an optional idle burst first
  task automatic send_item(logic [BYTE_W-1:0] b, logic l);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      src_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    src_if.valid    <= 1'b1;
    src_if.src_byte <= b;
    src_if.src_last <= l;
    do @(posedge clk_i); while (!src_if.ready);
    sb.take_source(b, l);
    src_count++;
  endtask

  // Drop valid and wait for the next clock edge so the next offer starts clean
  task automatic stop_source();
    src_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every expected item, then let the pipeline settle
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_window(int unsigned start_v, int unsigned len_v);
    settle();
    write_reg(CFG_START_BIT, start_v);
    write_reg(CFG_LENGTH_BITS, len_v);
  endtask

  // Stream of random bytes, last one flagged
  task automatic random_stream(int unsigned n_bytes);
    for (int unsigned i = 0; i < n_bytes; i++)
      send_item(BYTE_W'($urandom_range(0, 255)), i == n_bytes - 1);
    stop_source();
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        res_if.ready <= 1'b1;
      end else if (res_idle_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.out_byte, res_if.out_last, res_if.status);
  end

  // Run limit
  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned start_v, len_v, need, n_streams, n_bytes, rand_base;
    sb              = new();
    src_count       = 0;
    src_idle_on     = 1'b1;
    res_idle_on     = 1'b1;
    hold_req        = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_START_BIT;
    cfg_wdata_i     = '0;
    src_if.valid    = 1'b0;
    src_if.src_byte = '0;
    src_if.src_last = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero length: nothing comes out
    set_window(0, 0);
    send_item(8'hA5, 1'b1);
    stop_source();

    // Single full byte, trailing byte ignored
    set_window(0, 8);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    stop_source();

    // Unaligned window across two source bytes
    set_window(3, 13);
    send_item(8'h5A, 1'b0);
    send_item(8'hC3, 1'b0);
    send_item(8'h00, 1'b1);
    stop_source();

    // Short source where the last byte also completes a data byte, replaced by the error item
    set_window(5, 20);
    send_item(8'hFF, 1'b0);
    send_item(8'h81, 1'b1);
    stop_source();

    // Largest start value and a long length, source far too short
    set_window(65535, 65536);
    send_item(8'h7E, 1'b1);
    stop_source();

    // Writes in the middle of a stream: start now, length at next stream
    set_window(2, 10);
    send_item(8'hF0, 1'b0);
    stop_source();
    set_window(0, 7);
    send_item(8'h0F, 1'b0);
    send_item(8'h33, 1'b1);
    send_item(8'hAA, 1'b1);
    stop_source();

    // Long receiver hold while the source keeps offering
    set_window(0, 160);
    hold_req = 1'b1;
    random_stream(24);

    // Random phases
    rand_base = src_count;
    while (src_count - rand_base < RAND_ITEMS) begin
      if (src_count - rand_base >= RAND_ITEMS - CALM_ITEMS) begin
        src_idle_on = 1'b0;
        res_idle_on = 1'b0;
      end
      start_v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 31);
      case ($urandom_range(0, 9))
        0:       len_v = 0;
        1:       len_v = $urandom_range(72, 300);
        default: len_v = $urandom_range(1, 72);
      endcase
      set_window(start_v, len_v);
      need = (start_v + len_v + 7) / 8;
      if (need == 0) need = 1;
      n_streams = $urandom_range(1, 3);
      for (int unsigned s = 0; s < n_streams; s++) begin
        if (len_v == 0) n_bytes = $urandom_range(1, 4);
        else if ($urandom_range(0, 4) == 0) n_bytes = $urandom_range(1, need);
        else n_bytes = need + $urandom_range(0, 3);
        random_stream(n_bytes);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: bit_window_extract.f
sv/bwe_pkg.sv
sv/bwe_src_if.sv
sv/bwe_res_if.sv
sv/bit_window_extract.sv
sv/bwe_checker.sv
tb/tb_bit_window_extract.sv
